[hdl/irigfe_pkg.sv]
// Shared types, codes and BCD helpers for the IRIG-B frame encoder.
package irigfe_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam int SYMBOL_W   = 3;
	localparam int POSITION_W = 7;
	localparam int DIGIT_W    = 4;
	localparam int SOD_W      = 17;

	localparam logic [SYMBOL_W-1:0] SYM_ZERO = 3'd0;
	localparam logic [SYMBOL_W-1:0] SYM_ONE  = 3'd1;
	localparam logic [SYMBOL_W-1:0] SYM_REF  = 3'd2;
	localparam logic [SYMBOL_W-1:0] SYM_POS  = 3'd3;
	localparam logic [SYMBOL_W-1:0] SYM_IDX  = 3'd4;

	localparam logic [POSITION_W-1:0] LAST_POSITION = 7'd99;
	localparam logic [DIGIT_W-1:0]    LAST_DIGIT    = 4'd9;

	localparam logic [5:0]       SEC_MAX = 6'd59;
	localparam logic [5:0]       MIN_MAX = 6'd59;
	localparam logic [4:0]       HR_MAX  = 5'd23;
	localparam logic [8:0]       DAY_MAX = 9'd366;
	localparam logic [6:0]       YR_MAX  = 7'd99;
	localparam logic [SOD_W-1:0] SOD_MAX = 17'd86399;

	typedef struct packed {
		logic [3:0]       sec_u;
		logic [2:0]       sec_t;
		logic [3:0]       min_u;
		logic [2:0]       min_t;
		logic [3:0]       hr_u;
		logic [1:0]       hr_t;
		logic [3:0]       day_u;
		logic [3:0]       day_t;
		logic [1:0]       day_h;
		logic [3:0]       yr_u;
		logic [3:0]       yr_t;
		logic [SOD_W-1:0] sod;
	} bcd_time_t;

	function automatic logic [7:0] bcd_two(input logic [6:0] v);
		logic [3:0] t;
		logic [6:0] r;
		t = '0;
		for (int i = 1; i < 10; i++) begin
			if (v >= 7'(i * 10)) t = 4'(i);
		end
		r = v - 7'(int'(t) * 10);
		return {t, r[3:0]};
	endfunction

	function automatic logic [9:0] bcd_three(input logic [8:0] v);
		logic [1:0] h;
		logic [8:0] r;
		if (v >= 9'd300)      h = 2'd3;
		else if (v >= 9'd200) h = 2'd2;
		else if (v >= 9'd100) h = 2'd1;
		else                  h = 2'd0;
		r = v - 9'(int'(h) * 100);
		return {h, bcd_two(r[6:0])};
	endfunction

endpackage

[hdl/irig_b_frame_encoder.sv]
// IRIG-B time code frame encoder top level.
//
// Input channel (in_valid/in_ready): command selects a load or a tick. A load
// saturates each time field to its range and stores it as the pending time;
// it produces no output. A tick emits the next of the 100 frame symbols.
// At frame position 0 the pending time becomes the active time and the whole
// frame is drawn from it; a load in mid-frame only changes the pending time.
// Output channel (out_valid/out_ready): symbol, bit_position and frame_last,
// which is high on position 99. After position 99 the next tick starts a new
// frame at position 0.
// An accepted item is first held in the input register and then decoded
// into the output register. One item per cycle is taken while the output
// is drained each cycle. When the receiver stalls, the output register
// holds and one more item waits in the input register; loads still pass
// the stalled output.
// Reset clears the pending and active time to zero, restarts the frame at
// position 0 and empties both registers.
module irig_b_frame_encoder import irigfe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [5:0]            seconds,
	input  logic [5:0]            minutes,
	input  logic [4:0]            hours,
	input  logic [8:0]            day_of_year,
	input  logic [6:0]            year_of_century,
	input  logic [SOD_W-1:0]      seconds_of_day,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SYMBOL_W-1:0]   symbol,
	output logic [POSITION_W-1:0] bit_position,
	output logic                  frame_last
);

	logic                  valid_s1;
	logic                  cmd_s1;
	logic [5:0]            sec_s1;
	logic [5:0]            min_s1;
	logic [4:0]            hr_s1;
	logic [8:0]            day_s1;
	logic [6:0]            yr_s1;
	logic [SOD_W-1:0]      sod_s1;

	bcd_time_t             pending_q;
	bcd_time_t             active_q;
	bcd_time_t             load_time;
	bcd_time_t             frame_time;
	logic [POSITION_W-1:0] pos_q;
	logic [DIGIT_W-1:0]    dec_q;
	logic [DIGIT_W-1:0]    unit_q;
	logic                  out_valid_q;
	logic [SYMBOL_W-1:0]   symbol_q;
	logic [POSITION_W-1:0] position_q;
	logic                  last_q;

	logic                  out_free;
	logic                  take_s1;
	logic                  do_load;
	logic                  do_tick;
	logic [SYMBOL_W-1:0]   next_symbol;
	logic [5:0]            sec_sat;
	logic [5:0]            min_sat;
	logic [4:0]            hr_sat;
	logic [8:0]            day_sat;
	logic [6:0]            yr_sat;
	logic [7:0]            sec_bcd;
	logic [7:0]            min_bcd;
	logic [7:0]            hr_bcd;
	logic [9:0]            day_bcd;
	logic [7:0]            yr_bcd;

	assign out_free = !out_valid_q || out_ready;
	assign take_s1  = valid_s1 && (cmd_s1 == CMD_LOAD || out_free);
	assign do_load  = take_s1 && cmd_s1 == CMD_LOAD;
	assign do_tick  = take_s1 && cmd_s1 == CMD_TICK;
	assign in_ready = !valid_s1 || take_s1;

	always_comb begin
		sec_sat = (sec_s1 > SEC_MAX) ? SEC_MAX : sec_s1;
		min_sat = (min_s1 > MIN_MAX) ? MIN_MAX : min_s1;
		hr_sat  = (hr_s1 > HR_MAX) ? HR_MAX : hr_s1;
		day_sat = (day_s1 > DAY_MAX) ? DAY_MAX : day_s1;
		yr_sat  = (yr_s1 > YR_MAX) ? YR_MAX : yr_s1;
		sec_bcd = bcd_two({1'b0, sec_sat});
		min_bcd = bcd_two({1'b0, min_sat});
		hr_bcd  = bcd_two({2'b0, hr_sat});
		day_bcd = bcd_three(day_sat);
		yr_bcd  = bcd_two(yr_sat);
		load_time.sec_u = sec_bcd[3:0];
		load_time.sec_t = sec_bcd[6:4];
		load_time.min_u = min_bcd[3:0];
		load_time.min_t = min_bcd[6:4];
		load_time.hr_u  = hr_bcd[3:0];
		load_time.hr_t  = hr_bcd[5:4];
		load_time.day_u = day_bcd[3:0];
		load_time.day_t = day_bcd[7:4];
		load_time.day_h = day_bcd[9:8];
		load_time.yr_u  = yr_bcd[3:0];
		load_time.yr_t  = yr_bcd[7:4];
		load_time.sod   = (sod_s1 > SOD_MAX) ? SOD_MAX : sod_s1;
	end

	assign frame_time = (pos_q == '0) ? pending_q : active_q;

	irigfe_symbol_gen u_symbol_gen (
		.decade (dec_q),
		.unit   (unit_q),
		.tm     (frame_time),
		.symbol (next_symbol)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= command;
			sec_s1 <= seconds;
			min_s1 <= minutes;
			hr_s1  <= hours;
			day_s1 <= day_of_year;
			yr_s1  <= year_of_century;
			sod_s1 <= seconds_of_day;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			active_q    <= '0;
			pos_q       <= '0;
			dec_q       <= '0;
			unit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= do_tick || (out_valid_q && !out_ready);
			if (do_load) begin
				pending_q <= load_time;
			end
			if (do_tick) begin
				active_q    <= frame_time;
				pos_q       <= (pos_q == LAST_POSITION) ? '0 : pos_q + 1'b1;
				if (unit_q == LAST_DIGIT) begin
					unit_q <= '0;
					dec_q  <= (dec_q == LAST_DIGIT) ? '0 : dec_q + 1'b1;
				end else begin
					unit_q <= unit_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_tick) begin
			symbol_q   <= next_symbol;
			position_q <= pos_q;
			last_q     <= pos_q == LAST_POSITION;
		end
	end

	assign out_valid    = out_valid_q;
	assign symbol       = symbol_q;
	assign bit_position = position_q;
	assign frame_last   = last_q;

endmodule

[hdl/irigfe_symbol_gen.sv]
// Frame layout decode: symbol for one decade and unit position of the frame.
module irigfe_symbol_gen import irigfe_pkg::*; (
	input  logic [DIGIT_W-1:0]  decade,
	input  logic [DIGIT_W-1:0]  unit,
	input  bcd_time_t           tm,
	output logic [SYMBOL_W-1:0] symbol
);

	logic [9:0] data;
	logic [9:0] idx_mask;

	always_comb begin
		data     = '0;
		idx_mask = '0;
		unique case (decade)
			4'd0: begin
				data     = {1'b0, tm.sec_t, 1'b0, tm.sec_u, 1'b0};
				idx_mask = 10'b0000100000;
			end
			4'd1: begin
				data     = {2'b0, tm.min_t, 1'b0, tm.min_u};
				idx_mask = 10'b0100010000;
			end
			4'd2: begin
				data     = {3'b0, tm.hr_t, 1'b0, tm.hr_u};
				idx_mask = 10'b0110010000;
			end
			4'd3: begin
				data     = {1'b0, tm.day_t, 1'b0, tm.day_u};
				idx_mask = 10'b0000010000;
			end
			4'd4: begin
				data     = {8'b0, tm.day_h};
				idx_mask = 10'b0111111100;
			end
			4'd5: begin
				data     = {1'b0, tm.yr_t, 1'b0, tm.yr_u};
				idx_mask = 10'b0000010000;
			end
			4'd8: begin
				data     = {1'b0, tm.sod[8:0]};
			end
			4'd9: begin
				data     = {2'b0, tm.sod[16:9]};
				idx_mask = 10'b0100000000;
			end
			default: begin
				data     = '0;
				idx_mask = '0;
			end
		endcase
	end

	always_comb begin
		if (unit == LAST_DIGIT) begin
			symbol = SYM_POS;
		end else if (decade == '0 && unit == '0) begin
			symbol = SYM_REF;
		end else if (idx_mask[unit]) begin
			symbol = SYM_IDX;
		end else if (data[unit]) begin
			symbol = SYM_ONE;
		end else begin
			symbol = SYM_ZERO;
		end
	end

endmodule

[hdl/irigfe_checker.sv]
// Port-level checker for the IRIG-B frame encoder and its bind.
module irigfe_checker import irigfe_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [SYMBOL_W-1:0]   symbol,
	input logic [POSITION_W-1:0] bit_position,
	input logic                  frame_last
);

	logic                  seen_q;
	logic [POSITION_W-1:0] prev_pos_q;
	logic                  out_xfer;

	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			prev_pos_q <= '0;
		end else if (out_xfer) begin
			seen_q     <= 1'b1;
			prev_pos_q <= bit_position;
		end
	end

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_last == (bit_position == LAST_POSITION)))
		else $error("frame_last does not match position 99");

	a_ref_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((symbol == SYM_REF) == (bit_position == '0)))
		else $error("reference mark not exactly at position 0");

	a_symbol_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (symbol <= SYM_IDX && bit_position <= LAST_POSITION))
		else $error("symbol code or position out of range");

	a_position_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && seen_q) |->
			(bit_position == ((prev_pos_q == LAST_POSITION) ? '0 : prev_pos_q + 1'b1)))
		else $error("output positions skip or repeat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(bit_position) && $stable(symbol)))
		else $error("stalled output transfer changed");

endmodule

bind irig_b_frame_encoder irigfe_checker u_irigfe_checker (.*);

[bench/irig_b_frame_encoder_tb.sv]
// Self-checking bench for the IRIG-B frame encoder: directed and random loads and ticks.
`timescale 1ns / 100ps

module irig_b_frame_encoder_tb import irigfe_pkg::*;;

	typedef struct {
		logic                  cmd;
		logic [5:0]            sec;
		logic [5:0]            mins;
		logic [4:0]            hrs;
		logic [8:0]            day;
		logic [6:0]            year;
		logic [SOD_W-1:0]      sod;
	} frame_item_t;

	typedef struct {
		int unsigned sec;
		int unsigned mins;
		int unsigned hrs;
		int unsigned day;
		int unsigned year;
		int unsigned sod;
	} clock_time_t;

	typedef struct {
		logic [SYMBOL_W-1:0]   sym;
		logic [POSITION_W-1:0] pos;
		logic                  last;
	} frame_symbol_t;

	class symbol_tracker;
		clock_time_t   pending;
		clock_time_t   active;
		int unsigned   next_pos;
		frame_symbol_t due_symbols[$];
		int unsigned   mismatches;

		function new();
			pending    = '{0, 0, 0, 0, 0, 0};
			active     = '{0, 0, 0, 0, 0, 0};
			next_pos   = 0;
			mismatches = 0;
		endfunction

		function logic [SYMBOL_W-1:0] bit_symbol(int unsigned v, int unsigned b);
			return ((v >> b) & 1) ? SYM_ONE : SYM_ZERO;
		endfunction

		function logic [SYMBOL_W-1:0] frame_symbol(int unsigned pos, clock_time_t t);
			int unsigned grp;
			int unsigned idx;
			grp = pos / 10;
			idx = pos % 10;
			if (pos == 0) return SYM_REF;
			if (idx == 9) return SYM_POS;
			case (grp)
				0: begin
					if (idx <= 4) return bit_symbol(t.sec % 10, idx - 1);
					if (idx == 5) return SYM_IDX;
					return bit_symbol(t.sec / 10, idx - 6);
				end
				1: begin
					if (idx <= 3) return bit_symbol(t.mins % 10, idx);
					if (idx == 4 || idx == 8) return SYM_IDX;
					return bit_symbol(t.mins / 10, idx - 5);
				end
				2: begin
					if (idx <= 3) return bit_symbol(t.hrs % 10, idx);
					if (idx == 4 || idx >= 7) return SYM_IDX;
					return bit_symbol(t.hrs / 10, idx - 5);
				end
				3: begin
					if (idx <= 3) return bit_symbol(t.day % 10, idx);
					if (idx == 4) return SYM_IDX;
					return bit_symbol((t.day / 10) % 10, idx - 5);
				end
				4: begin
					if (idx <= 1) return bit_symbol(t.day / 100, idx);
					return SYM_IDX;
				end
				5: begin
					if (idx <= 3) return bit_symbol(t.year % 10, idx);
					if (idx == 4) return SYM_IDX;
					return bit_symbol(t.year / 10, idx - 5);
				end
				8: return bit_symbol(t.sod, idx);
				9: begin
					if (idx == 8) return SYM_IDX;
					return bit_symbol(t.sod, 9 + idx);
				end
				default: return SYM_ZERO;
			endcase
		endfunction

		function int unsigned clamp(int unsigned v, int unsigned hi);
			return (v > hi) ? hi : v;
		endfunction

		function void take_item(frame_item_t item);
			frame_symbol_t want;
			if (item.cmd == CMD_LOAD) begin
				pending.sec  = clamp(item.sec, SEC_MAX);
				pending.mins = clamp(item.mins, MIN_MAX);
				pending.hrs  = clamp(item.hrs, HR_MAX);
				pending.day  = clamp(item.day, DAY_MAX);
				pending.year = clamp(item.year, YR_MAX);
				pending.sod  = clamp(item.sod, SOD_MAX);
			end else begin
				if (next_pos == 0) active = pending;
				want.sym  = frame_symbol(next_pos, active);
				want.pos  = POSITION_W'(next_pos);
				want.last = (next_pos == LAST_POSITION);
				due_symbols = {due_symbols, want};
				next_pos = (next_pos == LAST_POSITION) ? 0 : next_pos + 1;
			end
		endfunction

		task report(string what, int got, int want);
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
			mismatches++;
		endtask

		task check_symbol(logic [SYMBOL_W-1:0] sym, logic [POSITION_W-1:0] pos, logic last);
			frame_symbol_t want;
			if (due_symbols.size() == 0) begin
				report("unexpected symbol at position", pos, -1);
				return;
			end
			want = due_symbols.pop_front();
			if (sym !== want.sym) report("symbol", sym, want.sym);
			if (pos !== want.pos) report("bit_position", pos, want.pos);
			if (last !== want.last) report("frame_last", last, want.last);
		endtask
	endclass

	logic                  clk;
	logic                  arst_n          = 1'b0;
	logic                  in_valid        = 1'b0;
	logic                  in_ready;
	logic                  command         = CMD_LOAD;
	logic [5:0]            seconds         = '0;
	logic [5:0]            minutes         = '0;
	logic [4:0]            hours           = '0;
	logic [8:0]            day_of_year     = '0;
	logic [6:0]            year_of_century = '0;
	logic [SOD_W-1:0]      seconds_of_day  = '0;
	logic                  out_valid;
	logic                  out_ready       = 1'b0;
	logic [SYMBOL_W-1:0]   symbol;
	logic [POSITION_W-1:0] bit_position;
	logic                  frame_last;

	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;

	symbol_tracker tracker = new();

	irig_b_frame_encoder i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.seconds         (seconds),
		.minutes         (minutes),
		.hours           (hours),
		.day_of_year     (day_of_year),
		.year_of_century (year_of_century),
		.seconds_of_day  (seconds_of_day),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.symbol          (symbol),
		.bit_position    (bit_position),
		.frame_last      (frame_last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic frame_item_t make_load(int s, int m, int h, int d, int y, int sd);
		frame_item_t item;
		item.cmd  = CMD_LOAD;
		item.sec  = 6'(s);
		item.mins = 6'(m);
		item.hrs  = 5'(h);
		item.day  = 9'(d);
		item.year = 7'(y);
		item.sod  = SOD_W'(sd);
		return item;
	endfunction

	function automatic frame_item_t random_tick();
		frame_item_t item;
		item      = make_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		item.cmd  = CMD_TICK;
		return item;
	endfunction

	function automatic int boundary_value(int hi, int ones);
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return hi;
			2:       return hi + 1;
			default: return ones;
		endcase
	endfunction

	function automatic frame_item_t random_load();
		case ($urandom_range(0, 3))
			0: return make_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			1: return make_load(boundary_value(SEC_MAX, 63), boundary_value(MIN_MAX, 63),
				boundary_value(HR_MAX, 31), boundary_value(DAY_MAX, 511),
				boundary_value(YR_MAX, 127), boundary_value(SOD_MAX, 131071));
			default: return make_load($urandom_range(0, SEC_MAX), $urandom_range(0, MIN_MAX),
				$urandom_range(0, HR_MAX), $urandom_range(0, DAY_MAX),
				$urandom_range(0, YR_MAX), $urandom_range(0, SOD_MAX));
		endcase
	endfunction

	task drive_item(frame_item_t item);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, 16) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid        <= 1'b1;
		command         <= item.cmd;
		seconds         <= item.sec;
		minutes         <= item.mins;
		hours           <= item.hrs;
		day_of_year     <= item.day;
		year_of_century <= item.year;
		seconds_of_day  <= item.sod;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.take_item(item);
	endtask

	task drive_ticks(int unsigned count);
		repeat (count) drive_item(random_tick());
	endtask

	task hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.due_symbols.size() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = recv_idle ? $urandom_range(0, 16) : 0;
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			tracker.check_symbol(symbol, bit_position, frame_last);
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// saturate every field, then start a frame from it
		drive_item(make_load(63, 63, 31, 511, 127, 131071));
		drive_ticks(9);
		// load in mid-frame must not disturb the frame in flight
		drive_item(make_load(0, 0, 0, 0, 0, 0));
		drive_ticks(5);
		drive_item(make_load(SEC_MAX, MIN_MAX, HR_MAX, DAY_MAX, YR_MAX, SOD_MAX));
		drive_item(make_load(SEC_MAX + 1, MIN_MAX + 1, HR_MAX + 1, DAY_MAX + 1, YR_MAX + 1,
			SOD_MAX + 1));
		drive_ticks(6);
		hold_until_drained();

		for (int n = 0; n < 2000; n++) begin
			if (n % 100 == 0) begin
				send_idle = ($urandom_range(0, 3) != 0);
				recv_idle = ($urandom_range(0, 3) != 0);
			end
			if (n == 1000) hold_until_drained();
			if ($urandom_range(0, 7) == 0) drive_item(random_load());
			else drive_item(random_tick());
		end

		hold_until_drained();
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end

endmodule
